// ===== hdl/partition_fit_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// partition_fit_allocator assertion macros
// shared concurrent assertion shorthands, sampled on clk, disabled in rst
// ---------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("partition_fit_allocator assertion failed");

// next-cycle implication
`define PFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("partition_fit_allocator assertion failed");

`endif

// ===== hdl/pfa_pkg.sv =====
// ---------------------------------------------------------------------------
// pfa_pkg
// shared types and codes of the partition fit allocator
// ---------------------------------------------------------------------------
package pfa_pkg;

  // one partition record as held in the table
  typedef struct packed {
    logic        full;
    logic [15:0] tally;
    logic [15:0] vacant;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  localparam logic       REQ_LOAD  = 1'b0;
  localparam logic       REQ_ALLOC = 1'b1;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam logic [1:0] STATUS_LOADED = 2'd0;
  localparam logic [1:0] STATUS_PLACED = 2'd1;
  localparam logic [1:0] STATUS_NOFIT  = 2'd2;

  localparam logic [0:0] REG_FIT_POLICY = 1'b0;
  localparam logic [0:0] REG_PARTS_USED = 1'b1;

  localparam logic [1:0] FIT_POLICY_RST = 2'd0;
  localparam logic [3:0] PARTS_USED_RST = 4'd8;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

// ===== hdl/pfa_table.sv =====
// ---------------------------------------------------------------------------
// pfa_table
// partition record memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pfa_table #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output pfa_pkg::entry_t      rd_entry,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  pfa_pkg::entry_t      wr_entry
);

  pfa_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld;       // entry written since reset
  pfa_pkg::entry_t  rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // unwritten entries read as the reset record
  assign rd_entry = rd_vld ? rd_q : '0;

endmodule

// ===== hdl/partition_fit_allocator.sv =====
// ---------------------------------------------------------------------------
// partition_fit_allocator
// fixed-partition allocator with first, best or worst fit selection
// ---------------------------------------------------------------------------
// usage
//   s_* stream carries one item per transfer: tuser is the kind (load or
//   allocate), tdata the slot and size. m_* stream returns one result per
//   item: tuser the status, tdata partition, space left and occupant count.
//   the apb port holds fit_policy (0x0) and partitions_in_use (0x4); write
//   them only while no item is in flight.
// sequencing
//   a load completes in the accept cycle; its result shows in the next cycle.
//   an allocate walks the partition table through its single read port,
//   one record a cycle, with one comparator, over the first
//   min(partitions_in_use, PARTITIONS) records; no new item is accepted
//   until its result has been registered.
// reset
//   synchronous; every partition reads as empty, size 0, not full, count 0.
//   fit_policy returns to first fit, partitions_in_use to 8.
// back-pressure
//   the result sits in an output register; while it waits the input is
//   held off and a finished search holds its write-back, so nothing is lost.
// ---------------------------------------------------------------------------
module partition_fit_allocator #(
  parameter int PARTITIONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // partition_slot[2:0], request_size[18:3], zero pad
  input  logic [0:0]  s_tuser,   // req_type[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // chosen_partition[2:0], space_left[18:3],
                                 // occupant_count[34:19], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W = $clog2(PARTITIONS + 1);

  // configuration registers
  logic [1:0] fit_policy;
  logic [3:0] parts_used;

  // control
  pfa_pkg::state_t  state;
  logic [15:0]      req_size;
  logic [CNT_W-1:0] rd_idx;      // next record to read
  logic [CNT_W-1:0] limit;       // records to search
  logic             rd_pend;     // read data arrives this cycle
  logic [IDX_W-1:0] eval_idx;    // record index of that data
  logic             found;
  logic [IDX_W-1:0] pick_idx;
  pfa_pkg::entry_t  pick_ent;

  // table ports
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  pfa_pkg::entry_t  rd_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pfa_pkg::entry_t  wr_entry;

  // input fields
  logic        in_type;
  logic [2:0]  in_slot;
  logic [15:0] in_size;
  logic        in_xfer;
  logic        slot_ok;

  logic        out_free;
  logic        issue;
  logic        fits;
  logic        take;
  logic [15:0] new_vac;
  logic [15:0] new_tally;
  logic        new_full;
  logic        commit;

  assign in_type = s_tuser[0];
  assign in_slot = s_tdata[2:0];
  assign in_size = s_tdata[18:3];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == pfa_pkg::ST_IDLE) && out_free;
  assign in_xfer  = s_tvalid && s_tready;
  assign slot_ok  = 32'(in_slot) < PARTITIONS;
  assign commit   = (state == pfa_pkg::ST_COMMIT) && out_free;

  // ------------------------------------------------------------------
  // apb configuration port
  // ------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= pfa_pkg::FIT_POLICY_RST;
      parts_used <= pfa_pkg::PARTS_USED_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2:2])
        pfa_pkg::REG_FIT_POLICY: fit_policy <= pwdata[1:0];
        pfa_pkg::REG_PARTS_USED: parts_used <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      pfa_pkg::REG_FIT_POLICY: prdata = {30'd0, fit_policy};
      pfa_pkg::REG_PARTS_USED: prdata = {28'd0, parts_used};
      default:                 prdata = '0;
    endcase
  end

  // search bound saturates at the table depth
  assign limit = (32'(parts_used) > PARTITIONS) ? CNT_W'(PARTITIONS) : CNT_W'(parts_used);

  // ------------------------------------------------------------------
  // scan: one read issued and one record compared per cycle
  // ------------------------------------------------------------------
  assign issue   = (state == pfa_pkg::ST_SCAN) && (rd_idx < limit);
  assign rd_en   = issue;
  assign rd_addr = rd_idx[IDX_W-1:0];

  assign fits = rd_pend && !rd_entry.full && (rd_entry.vacant >= req_size);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found) begin
        take = 1'b1;
      end else begin
        case (fit_policy)
          pfa_pkg::POLICY_BEST:  take = rd_entry.vacant < pick_ent.vacant;
          pfa_pkg::POLICY_WORST: take = rd_entry.vacant > pick_ent.vacant;
          default:               take = 1'b0;   // first fit keeps the lowest index
        endcase
      end
    end
  end

  // updated record of the chosen partition
  assign new_vac   = pick_ent.vacant - req_size;
  assign new_full  = pick_ent.full || (new_vac == 16'd0);
  assign new_tally = (pick_ent.tally == pfa_pkg::COUNT_MAX) ? pick_ent.tally
                                                            : pick_ent.tally + 16'd1;

  // single write port: load in idle, write-back in commit
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pick_idx;
    wr_entry = '{full: new_full, tally: new_tally, vacant: new_vac};
    if (in_xfer && in_type == pfa_pkg::REQ_LOAD && slot_ok) begin
      wr_en    = 1'b1;
      wr_addr  = IDX_W'(in_slot);
      wr_entry = '{full: 1'b0, tally: 16'd0, vacant: in_size};
    end else if (commit && found) begin
      wr_en = 1'b1;
    end
  end

  pfa_table #(
    .DEPTH (PARTITIONS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pfa_pkg::ST_IDLE;
      rd_pend <= 1'b0;
      found   <= 1'b0;
      rd_idx  <= '0;
    end else begin
      unique case (state)
        pfa_pkg::ST_IDLE: begin
          if (in_xfer && in_type == pfa_pkg::REQ_ALLOC) begin
            state   <= pfa_pkg::ST_SCAN;
            rd_idx  <= '0;
            rd_pend <= 1'b0;
            found   <= 1'b0;
          end
        end
        pfa_pkg::ST_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (take) begin
            found <= 1'b1;
          end
          // last compare done once nothing is issued or in flight
          if (!issue && !rd_pend) begin
            state <= pfa_pkg::ST_COMMIT;
          end
        end
        pfa_pkg::ST_COMMIT: begin
          if (out_free) begin
            state <= pfa_pkg::ST_IDLE;
          end
        end
        default: state <= pfa_pkg::ST_IDLE;
      endcase
    end
  end

  // payload registers of the scan
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_size <= in_size;
    end
    if (issue) begin
      eval_idx <= rd_addr;
    end
    if (take) begin
      pick_idx <= eval_idx;
      pick_ent <= rd_entry;
    end
  end

  // ------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((in_xfer && in_type == pfa_pkg::REQ_LOAD) || commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_type == pfa_pkg::REQ_LOAD) begin
      m_tuser <= pfa_pkg::STATUS_LOADED;
      m_tdata <= {5'd0, 16'd0, (slot_ok ? in_size : 16'd0), in_slot};
    end else if (commit) begin
      if (found) begin
        m_tuser <= pfa_pkg::STATUS_PLACED;
        m_tdata <= {5'd0, new_tally, new_vac, 3'(pick_idx)};
      end else begin
        m_tuser <= pfa_pkg::STATUS_NOFIT;
        m_tdata <= '0;
      end
    end
  end

endmodule

// ===== hdl/pfa_checker.sv =====
// ---------------------------------------------------------------------------
// pfa_checker
// port-level checks of the partition fit allocator
// ---------------------------------------------------------------------------
`include "partition_fit_allocator_defines.svh"

module pfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  `PFA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // an allocate occupies the block for its search
  `PFA_ASSERT_NXT(a_alloc_busy, s_tvalid && s_tready && s_tuser[0] == pfa_pkg::REQ_ALLOC,
    !s_tready)

  // no fit reports all-zero fields
  `PFA_ASSERT_IMP(a_nofit_zero, m_tvalid && m_tuser == pfa_pkg::STATUS_NOFIT,
    m_tdata == 40'd0)

  // a freshly loaded partition holds no requests
  `PFA_ASSERT_IMP(a_load_count, m_tvalid && m_tuser == pfa_pkg::STATUS_LOADED,
    m_tdata[34:19] == 16'd0)

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: partition fit allocator regression
// drives load and allocate transfers into the allocator, predicts every
// result with a behavioural copy of the partition table and compares each
// returned transfer field by field; covers all fit policies, partition
// counts from zero to fifteen and back-pressure
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 8;
  localparam int PARTS          = 8;
  localparam int IDLE_PCT       = 18;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 100;
  localparam int N_DIRECTED     = 32;

  // spare policy code, expected to fall back to first fit
  localparam logic [1:0] POLICY_SPARE = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [15:0] size;
  } alloc_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  part;
    logic [15:0] space;
    logic [15:0] count;
  } alloc_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  // one directed row: either a register write or an item, with an optional
  // hand-typed result
  typedef struct packed {
    row_op_t     row_op;
    logic [0:0]  reg_idx;
    logic [3:0]  reg_val;
    logic        req;
    logic [2:0]  slot;
    logic [15:0] size;
    logic        typed;
    logic [1:0]  status;
    logic [2:0]  part;
    logic [15:0] space;
    logic [15:0] count;
  } dir_row_t;

  // dut signals, all inputs known from time zero
  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // partition_slot[2:0], request_size[18:3], zero pad
  logic [0:0]  s_tuser  = '0;   // req_type[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // chosen_partition[2:0], space_left[18:3],
                                // occupant_count[34:19], zero pad
  logic [1:0]  m_tuser;         // status[1:0]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the partition table and registers
  logic [15:0] vacant_tab [PARTS];
  logic        full_tab   [PARTS];
  logic [15:0] tally_tab  [PARTS];
  logic [1:0]  policy_reg;
  logic [3:0]  used_reg;

  alloc_result_t pending_outcomes [$];
  int            mismatches    = 0;
  int            quiet_cycles  = 0;
  bit            idle_on       = 1'b1;
  int            hold_requests = 0;
  int            hold_served   = 0;
  int            hold_left     = 0;

  // kind      reg             val                   req        slot  size
  //   typed status          part  space     count
  dir_row_t directed_rows [N_DIRECTED] = '{
    // empty table after reset: zero-size requests fill the empty partitions
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'h0000,
      1'b1, pfa_pkg::STATUS_PLACED, 3'd0, 16'h0000, 16'd1},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'h0000,
      1'b1, pfa_pkg::STATUS_PLACED, 3'd1, 16'h0000, 16'd1},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd5, 16'hFFFF,
      1'b1, pfa_pkg::STATUS_NOFIT, 3'd0, 16'h0000, 16'd0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd7, 16'hFFFF,
      1'b1, pfa_pkg::STATUS_LOADED, 3'd7, 16'hFFFF, 16'd0},
    // load of size zero clears the full mark
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd0, 16'h0000,
      1'b1, pfa_pkg::STATUS_LOADED, 3'd0, 16'h0000, 16'd0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd1, 16'd100, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd2, 16'd50, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd3, 16'd200, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd4, 16'd50, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd6, 16'd40, 1'b0, '0, '0, '0, '0},
    // best fit with a tie between two partitions
    '{ROW_CFG, pfa_pkg::REG_FIT_POLICY, {2'b0, pfa_pkg::POLICY_BEST},
      '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'd50, 1'b0, '0, '0, '0, '0},
    '{ROW_CFG, pfa_pkg::REG_FIT_POLICY, {2'b0, pfa_pkg::POLICY_WORST},
      '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'd1, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'hFFFE, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'hFFFF,
      1'b1, pfa_pkg::STATUS_NOFIT, 3'd0, 16'h0000, 16'd0},
    // spare policy code acts as first fit
    '{ROW_CFG, pfa_pkg::REG_FIT_POLICY, {2'b0, POLICY_SPARE},
      '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'h0000, 1'b0, '0, '0, '0, '0},
    // nothing searched with zero partitions in use
    '{ROW_CFG, pfa_pkg::REG_PARTS_USED, 4'd0, '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'h0000,
      1'b1, pfa_pkg::STATUS_NOFIT, 3'd0, 16'h0000, 16'd0},
    // count above the table size saturates
    '{ROW_CFG, pfa_pkg::REG_PARTS_USED, 4'd15, '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'd10, 1'b0, '0, '0, '0, '0},
    '{ROW_CFG, pfa_pkg::REG_PARTS_USED, 4'd1, '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_CFG, pfa_pkg::REG_FIT_POLICY, {2'b0, pfa_pkg::POLICY_WORST},
      '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'h0000,
      1'b1, pfa_pkg::STATUS_NOFIT, 3'd0, 16'h0000, 16'd0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd0, 16'hFFFF,
      1'b1, pfa_pkg::STATUS_LOADED, 3'd0, 16'hFFFF, 16'd0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'hFFFF,
      1'b1, pfa_pkg::STATUS_PLACED, 3'd0, 16'h0000, 16'd1},
    // best fit picks an empty but not full partition for a zero request
    '{ROW_CFG, pfa_pkg::REG_PARTS_USED, 4'd8, '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_CFG, pfa_pkg::REG_FIT_POLICY, {2'b0, pfa_pkg::POLICY_BEST},
      '0, '0, '0, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd5, 16'd7, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_LOAD, 3'd6, 16'h0000, 1'b0, '0, '0, '0, '0},
    '{ROW_ITEM, '0, '0, pfa_pkg::REQ_ALLOC, 3'd0, 16'h0000, 1'b0, '0, '0, '0, '0}
  };

  partition_fit_allocator #(.PARTITIONS(PARTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // applies one item to the predicted table and returns its result
  function automatic alloc_result_t load_or_place(input alloc_item_t it);
    alloc_result_t r;
    int            pick;
    int            limit;
    logic [15:0]   pick_space;
    r = '0;
    if (it.kind == pfa_pkg::REQ_LOAD) begin
      vacant_tab[it.slot] = it.size;
      full_tab[it.slot]   = 1'b0;
      tally_tab[it.slot]  = '0;
      r.status = pfa_pkg::STATUS_LOADED;
      r.part   = it.slot;
      r.space  = it.size;
      return r;
    end
    limit      = (used_reg > PARTS) ? PARTS : int'(used_reg);
    pick       = -1;
    pick_space = '0;
    // only best and worst fit move away from the first candidate
    for (int i = 0; i < limit; i++) begin
      if (!full_tab[i] && vacant_tab[i] >= it.size) begin
        if (pick < 0) begin
          pick       = i;
          pick_space = vacant_tab[i];
        end else if (policy_reg == pfa_pkg::POLICY_BEST && vacant_tab[i] < pick_space) begin
          pick       = i;
          pick_space = vacant_tab[i];
        end else if (policy_reg == pfa_pkg::POLICY_WORST && vacant_tab[i] > pick_space) begin
          pick       = i;
          pick_space = vacant_tab[i];
        end
      end
    end
    if (pick < 0) begin
      r.status = pfa_pkg::STATUS_NOFIT;
      return r;
    end
    vacant_tab[pick] = vacant_tab[pick] - it.size;
    if (vacant_tab[pick] == '0)
      full_tab[pick] = 1'b1;
    if (tally_tab[pick] != pfa_pkg::COUNT_MAX)
      tally_tab[pick] = tally_tab[pick] + 16'd1;
    r.status = pfa_pkg::STATUS_PLACED;
    r.part   = pick[2:0];
    r.space  = vacant_tab[pick];
    r.count  = tally_tab[pick];
    return r;
  endfunction

  function automatic void check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // offer one item, called and returning at a falling edge; valid stays high
  // into the next call unless that call idles first
  task automatic send_item(input alloc_item_t it, input logic typed,
                           input alloc_result_t want);
    alloc_result_t predicted;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {5'b0, it.size, it.slot};
    do @(posedge clk); while (!s_tready);
    predicted = load_or_place(it);
    pending_outcomes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // sender pause: nothing offered until every result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write, setup then access phase, then the bus returns to idle
  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == pfa_pkg::REG_FIT_POLICY)
      policy_reg = val[1:0];
    else
      used_reg = val;
    @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d part %0d",
                 $time, m_tuser, m_tdata[2:0]);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("chosen_partition", want.part, m_tdata[2:0]);
        check_field("space_left", want.space, m_tdata[18:3]);
        check_field("occupant_count", want.count, m_tdata[34:19]);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    alloc_item_t   it;
    alloc_result_t want;
    logic [3:0]    used_val;
    for (int i = 0; i < PARTS; i++) begin
      vacant_tab[i] = '0;
      full_tab[i]   = 1'b0;
      tally_tab[i]  = '0;
    end
    policy_reg = pfa_pkg::FIT_POLICY_RST;
    used_reg   = pfa_pkg::PARTS_USED_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].row_op == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        it   = '{directed_rows[i].req, directed_rows[i].slot, directed_rows[i].size};
        want = '{directed_rows[i].status, directed_rows[i].part,
                 directed_rows[i].space, directed_rows[i].count};
        send_item(it, directed_rows[i].typed, want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       used_val = 4'd8;
        1:       used_val = 4'd1;
        2:       used_val = 4'd15;
        3:       used_val = 4'd0;
        default: used_val = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(2, 8));
      endcase
      write_reg(pfa_pkg::REG_FIT_POLICY, {2'b0, 2'(p % 4)});
      write_reg(pfa_pkg::REG_PARTS_USED, used_val);
      // phase two runs without idling on either side
      idle_on = (p != 2);
      // long receiver hold-off so the block fills and stalls its input
      if (p == 4)
        hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.kind = ($urandom_range(0, 99) < 30) ? pfa_pkg::REQ_LOAD : pfa_pkg::REQ_ALLOC;
        it.slot = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0:       it.size = '0;
          1:       it.size = 16'($urandom);
          default: it.size = (it.kind == pfa_pkg::REQ_LOAD) ? 16'($urandom_range(1, 300))
                                                            : 16'($urandom_range(1, 80));
        endcase
        send_item(it, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== partition_fit_allocator.f =====
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_table.sv
hdl/partition_fit_allocator.sv
hdl/pfa_checker.sv
test/tb_top.sv
